// ----- hdl/ssnd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssnd_pkg
// Shared types, constants and lookup functions for the seven-segment serial
// number driver: controller states, command/status bundles, segment table.
// ----------------------------------------------------------------------------
package ssnd_pkg;

  localparam int unsigned ValueW    = 14;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned SegW      = 8;
  localparam int unsigned CntW      = 5;
  localparam int unsigned FselW     = 2;

  localparam logic [ValueW-1:0] ValueMax       = ValueW'(9999);
  localparam logic [ValueW-1:0] BlankThreshold = ValueW'(1000);
  localparam logic [CntW-1:0]   BlankLastBit   = CntW'(31);
  localparam logic [2:0]        DigitLastBit   = 3'd7;
  localparam logic [SegW-1:0]   BlankPattern   = 8'b0000_0000;

  // Factor select codes: power of ten of the digit being extracted.
  localparam logic [FselW-1:0] FselOnes      = 2'd0;
  localparam logic [FselW-1:0] FselTens      = 2'd1;
  localparam logic [FselW-1:0] FselHundreds  = 2'd2;
  localparam logic [FselW-1:0] FselThousands = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_DIGIT,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic load;      // capture the input item, pick the leading factor
    logic sub;       // subtract the factor once, bump the digit
    logic load_pat;  // move the digit's segment pattern into the shifter
    logic shift;     // advance the segment shifter one bit
    logic next_fac;  // step down one power of ten, clear the digit
    logic cnt_inc;   // advance the bit counter
    logic blank;     // drive the data line with blank level
  } cmd_t;

  typedef struct packed {
    logic blank_in;   // incoming value needs the four blank digits
    logic ge;         // remainder still holds another factor
    logic has_digits; // at least one significant digit to send
    logic blank_end;  // bit counter on last blank bit
    logic digit_end;  // bit counter on last bit of a digit
    logic fac_one;    // current factor is the ones place
  } sts_t;

  function automatic logic [ValueW-1:0] factor_of(input logic [FselW-1:0] fsel);
    logic [ValueW-1:0] f;
    case (fsel)
      FselOnes:      f = ValueW'(1);
      FselTens:      f = ValueW'(10);
      FselHundreds:  f = ValueW'(100);
      FselThousands: f = ValueW'(1000);
      default:       f = ValueW'(1);
    endcase
    return f;
  endfunction

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] p;
    case (digit)
      4'd0:    p = 8'b1111_1100;
      4'd1:    p = 8'b0110_0000;
      4'd2:    p = 8'b1101_1010;
      4'd3:    p = 8'b1111_0010;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b1011_0110;
      4'd6:    p = 8'b1011_1110;
      4'd7:    p = 8'b1110_0000;
      4'd8:    p = 8'b1111_1110;
      4'd9:    p = 8'b1111_0110;
      default: p = 8'b1111_0110;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/ssnd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssnd_ctrl
// Controller: sequences blank bits, digit extraction and segment shifting.
// ----------------------------------------------------------------------------
module ssnd_ctrl
  import ssnd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic strobe,
  output logic last
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = sts.blank_in ? ST_BLANK : ST_DIGIT;
        end
      end
      ST_BLANK: begin
        if (sts.blank_end) begin
          state_next = sts.has_digits ? ST_DIGIT : ST_IDLE;
        end
      end
      ST_DIGIT: begin
        if (!sts.ge) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.digit_end) begin
          state_next = sts.fac_one ? ST_IDLE : ST_DIGIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    last   = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_BLANK: begin
        cmd.blank   = 1'b1;
        cmd.cnt_inc = 1'b1;
        strobe      = 1'b1;
        last        = sts.blank_end && !sts.has_digits;
      end
      ST_DIGIT: begin
        cmd.sub      = sts.ge;
        cmd.load_pat = !sts.ge;
      end
      ST_SHIFT: begin
        cmd.shift    = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.next_fac = sts.digit_end && !sts.fac_one;
        strobe       = 1'b1;
        last         = sts.digit_end && sts.fac_one;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

// ----- hdl/ssnd_dpath.sv -----
// ----------------------------------------------------------------------------
// ssnd_dpath
// Datapath: saturation, remainder/digit by repeated subtraction, segment
// shifter and bit counter.
// ----------------------------------------------------------------------------
module ssnd_dpath
  import ssnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ValueW-1:0] value,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              data_level
);

  logic [ValueW-1:0] sat;
  logic [FselW-1:0]  lead_fsel;
  logic [ValueW-1:0] rem;
  logic [ValueW-1:0] factor;
  logic [FselW-1:0]  fsel;
  logic [DigitW-1:0] digit;
  logic [SegW-1:0]   shreg;
  logic [CntW-1:0]   cnt;
  logic              has_digits;

  assign sat = (value > ValueMax) ? ValueMax : value;

  always_comb begin
    if (sat >= ValueW'(1000)) begin
      lead_fsel = FselThousands;
    end else if (sat >= ValueW'(100)) begin
      lead_fsel = FselHundreds;
    end else if (sat >= ValueW'(10)) begin
      lead_fsel = FselTens;
    end else begin
      lead_fsel = FselOnes;
    end
  end

  assign factor = factor_of(fsel);

  // Control-side registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load || cmd.load_pat) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CntW'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem        <= sat;
      fsel       <= lead_fsel;
      digit      <= '0;
      has_digits <= (sat != '0);
      shreg      <= BlankPattern;
    end else begin
      if (cmd.sub) begin
        rem   <= rem - factor;
        digit <= digit + DigitW'(1);
      end
      if (cmd.next_fac) begin
        fsel  <= fsel - FselW'(1);
        digit <= '0;
      end
      if (cmd.load_pat) begin
        shreg <= seg_of(digit);
      end else if (cmd.shift) begin
        shreg <= {1'b0, shreg[SegW-1:1]};
      end
    end
  end

  assign sts.blank_in   = (sat < BlankThreshold);
  assign sts.ge         = (rem >= factor);
  assign sts.has_digits = has_digits;
  assign sts.blank_end  = (cnt == BlankLastBit);
  assign sts.digit_end  = (cnt[2:0] == DigitLastBit);
  assign sts.fac_one    = (fsel == FselOnes);

  // Active-low data line: a lit segment drives 0.
  assign data_level = cmd.blank ? 1'b1 : ~shreg[0];

endmodule

// ----- hdl/seven_segment_serial_number_driver.sv -----
// ----------------------------------------------------------------------------
// seven_segment_serial_number_driver
// Serial bit stream generator for a shift-register seven-segment display.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ------------------------------
//  command   in         start & !busy        value[13:0]
//  result    out        strobe (one cycle)   data_level, last
//
//  One item is taken at a time; busy stays high from the cycle after start
//  until the cycle after the bit flagged last. An item sends 32 blank bits when
//  the value is below 1000, then per significant digit d subtractions on the
//  shared digit extractor, one pattern load and 8 shifted bits (999 is the
//  longest run: blank bits plus three digits of nine subtractions each).
//  Reset is synchronous and returns the controller to idle. The receiver
//  cannot stall: each bit is shown for exactly one cycle with strobe high.
//
//  Stream: values below 1000 first send four blank digits (all bits at level
//  1). Then each significant decimal digit, most significant first, goes
//  out through the segment table, bit 0 first, active low. Zero sends only
//  the blank digits. Inputs above 9999 saturate to 9999.
// ----------------------------------------------------------------------------
module seven_segment_serial_number_driver
  import ssnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ValueW-1:0] value,
  output logic              busy,
  output logic              strobe,
  output logic              data_level,
  output logic              last
);

  cmd_t cmd;
  sts_t sts;

  // Controller: walks blank, extract and shift phases; owns the handshake.
  ssnd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .last   (last)
  );

  // Datapath: saturate, extract digits by repeated subtraction, shift out.
  ssnd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .data_level (data_level)
  );

  // Every accepted item starts a run.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Result bits only appear while an item is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("strobe while idle");

  // The last flag marks a real result bit.
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without strobe");

  // The run closes right after the final bit.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("still busy after final bit");

endmodule
